/* rtl/dwg_pkg.sv */
// ----------------------------------------------------------------------------
// dwg_pkg
// Shared constants, register map, stage record and the sine table builder
// for the DAC waveform generator.
// ----------------------------------------------------------------------------
package dwg_pkg;

   localparam int LEVEL_W    = 8;
   localparam int WAIT_W     = 21;
   localparam int SAMPLE_W   = 20;
   localparam int MODE_W     = 2;
   localparam int ROM_DEPTH  = 512;
   localparam int ROM_AW     = 9;
   localparam int CSR_DW     = 32;
   localparam int CSR_AW     = 4;
   localparam int REG_IDX_W  = 2;

   localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 8'hFF;
   localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 8'h00;
   localparam logic [ROM_AW-1:0]  TRI_FOLD   = 9'd511;
   localparam logic [ROM_AW-1:0]  TRI_PEAK   = 9'd255;

   localparam logic [MODE_W-1:0] MODE_SQUARE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TRIANGLE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SINE     = 2'd2;

   localparam logic [REG_IDX_W-1:0] REG_WAVE_MODE    = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_SAMPLE_TICKS = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_HIGH_TICKS   = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_LOW_TICKS    = 2'd3;

   localparam logic [MODE_W-1:0]   RST_WAVE_MODE    = MODE_SQUARE;
   localparam logic [SAMPLE_W-1:0] RST_SAMPLE_TICKS = 20'd10000;
   localparam logic [WAIT_W-1:0]   RST_HIGH_TICKS   = 21'd10000;
   localparam logic [WAIT_W-1:0]   RST_LOW_TICKS    = 21'd10000;

   // one accepted tick on its way to the output stage
   typedef struct packed {
      logic               strobe;
      logic               use_rom;
      logic [LEVEL_W-1:0] level;
   } tick_info_type;

   typedef logic [LEVEL_W-1:0] sine_rom_type [ROM_DEPTH];

   localparam longint unsigned PI_Q30   = 64'd3373259426;
   localparam longint          ONE_Q30  = 64'sd1073741824;
   localparam longint          CEIL_ADD = 64'sd2147483647 - 64'sd4096;

   // shift and subtract quotient, elaboration only
   function automatic longint unsigned div_u64(longint unsigned num,
                                               longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // fixed-point taylor series, evaluated at elaboration only
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type    rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned dv;
      longint          sum;
      longint          a;
      longint          n;
      int              h;
      int              j;
      for (int i = 0; i < ROM_DEPTH; i++) begin
         h = i & 255;
         j = (h <= 128) ? h : 256 - h;
         x = (longint'(j) * PI_Q30 + 64'd128) >> 8;
         x2 = (x * x) >> 30;
         term = x;
         sum = longint'(x);
         for (int k = 1; k <= 7; k++) begin
            dv = longint'((2 * k) * (2 * k + 1));
            term = div_u64((term * x2) >> 30, dv);
            if ((k & 1) != 0) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (i >= 256) begin
            a = 255 * (ONE_Q30 - sum);
         end else begin
            a = 255 * (ONE_Q30 + sum);
         end
         if (a < 0) begin
            a = 0;
         end
         n = (a + CEIL_ADD) >>> 31;
         if (n > 255) begin
            n = 255;
         end
         rom[i] = n[LEVEL_W-1:0];
      end
      return rom;
   endfunction

endpackage

/* rtl/dwg_sine_rom.sv */
// ----------------------------------------------------------------------------
// dwg_sine_rom
// Synchronous 512 x 8 sine table, registered read.
// ----------------------------------------------------------------------------
module dwg_sine_rom (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [dwg_pkg::ROM_AW-1:0]  rd_addr,
   output logic [dwg_pkg::LEVEL_W-1:0] rd_data
);
   import dwg_pkg::*;

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   logic [LEVEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= SINE_ROM[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/dwg_tick_ctrl.sv */
// ----------------------------------------------------------------------------
// dwg_tick_ctrl
// Per-tick pacing: countdown, square level, table phase and table index.
// Decides each transaction's write and issues the sine table read.
// ----------------------------------------------------------------------------
module dwg_tick_ctrl #(
   parameter int TABLE_DEPTH = 512
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic                         run,
   input  logic [dwg_pkg::MODE_W-1:0]   wave_mode,
   input  logic [dwg_pkg::SAMPLE_W-1:0] sample_ticks,
   input  logic [dwg_pkg::WAIT_W-1:0]   high_ticks,
   input  logic [dwg_pkg::WAIT_W-1:0]   low_ticks,
   output dwg_pkg::tick_info_type       info,
   output logic                         rom_rd_en,
   output logic [dwg_pkg::ROM_AW-1:0]   rom_addr
);
   import dwg_pkg::*;

   localparam int PH_W  = $clog2(TABLE_DEPTH);
   localparam int REM_W = $clog2(TABLE_DEPTH + ROM_DEPTH);
   localparam int MAX_STEP = (TABLE_DEPTH + ROM_DEPTH - 1) / TABLE_DEPTH;

   logic              square_ff, square_in;
   logic [WAIT_W-1:0] wait_ff,   wait_in;
   logic [PH_W-1:0]   phase_ff,  phase_in;
   logic [ROM_AW-1:0] idx_ff,    idx_in;
   logic [REM_W-1:0]  rem_ff,    rem_in;

   logic [REM_W-1:0]  rem_sum;
   logic [REM_W-1:0]  rem_step;
   logic [ROM_AW-1:0] idx_step;
   logic [WAIT_W-1:0] delay;

   // index = phase * 512 / depth, kept by stepping a remainder
   always_comb begin
      rem_sum  = rem_ff + REM_W'(ROM_DEPTH);
      rem_step = rem_sum;
      idx_step = idx_ff;
      for (int m = 1; m <= MAX_STEP; m++) begin
         if (int'(rem_sum) >= m * TABLE_DEPTH) begin
            rem_step = rem_sum - REM_W'(m * TABLE_DEPTH);
            idx_step = idx_ff + ROM_AW'(m);
         end
      end
   end

   always_comb begin
      square_in    = square_ff;
      wait_in      = wait_ff;
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      rem_in       = rem_ff;
      delay        = '0;
      info.strobe  = 1'b0;
      info.use_rom = 1'b0;
      info.level   = LEVEL_LOW;
      if (!run) begin
         wait_in = '0;
      end else if (wait_ff != '0) begin
         wait_in = wait_ff - WAIT_W'(1);
      end else begin
         info.strobe = 1'b1;
         if (wave_mode == MODE_SQUARE) begin
            info.level = square_ff ? LEVEL_HIGH : LEVEL_LOW;
            delay      = square_ff ? high_ticks : low_ticks;
            square_in  = !square_ff;
         end else begin
            info.level   = (idx_ff <= TRI_PEAK) ? idx_ff[LEVEL_W-1:0]
                                                : LEVEL_W'(TRI_FOLD - idx_ff);
            info.use_rom = (wave_mode != MODE_TRIANGLE);
            delay        = WAIT_W'(sample_ticks);
            if (phase_ff == PH_W'(TABLE_DEPTH - 1)) begin
               phase_in = '0;
               idx_in   = '0;
               rem_in   = '0;
            end else begin
               phase_in = phase_ff + PH_W'(1);
               idx_in   = idx_step;
               rem_in   = rem_step;
            end
         end
         wait_in = (delay == '0) ? '0 : delay - WAIT_W'(1);
      end
   end

   assign rom_rd_en = accept;
   assign rom_addr  = idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         square_ff <= 1'b0;
         wait_ff   <= '0;
         phase_ff  <= '0;
         idx_ff    <= '0;
         rem_ff    <= '0;
      end else if (accept) begin
         square_ff <= square_in;
         wait_ff   <= wait_in;
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         rem_ff    <= rem_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      accept && !run |=> wait_ff == '0)
      else $error("countdown not cleared by a stopped tick");

   assert property (@(posedge clock) disable iff (reset)
      int'(rem_ff) < TABLE_DEPTH)
      else $error("table index remainder out of range");

endmodule

/* rtl/dac_waveform_generator.sv */
// ----------------------------------------------------------------------------
// dac_waveform_generator
// Paced 8-bit DAC waveform source: square, triangle or sine table.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_run
//   rsp      out        rsp_valid / rsp_stall  rsp_dac_level, rsp_write_strobe
//   csr      in         apb, pready tied high  wave_mode, sample_ticks,
//                                              high_ticks, low_ticks
//
// one tick accepted per cycle while req_stall is low; each result passes
// through the registered sine table read and then the output register
// reset: synchronous, square mode, low level, first running tick writes
// no clearing pass; the table is a constant rom
// a stalled output holds one result and one tick in flight before req_stall
// ----------------------------------------------------------------------------
module dac_waveform_generator #(
   parameter int TABLE_DEPTH = 512
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_run,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [dwg_pkg::LEVEL_W-1:0] rsp_dac_level,
   output logic                        rsp_write_strobe,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [dwg_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [dwg_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [dwg_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import dwg_pkg::*;

   logic [MODE_W-1:0]   wave_mode_ff;
   logic [SAMPLE_W-1:0] sample_ticks_ff;
   logic [WAIT_W-1:0]   high_ticks_ff;
   logic [WAIT_W-1:0]   low_ticks_ff;

   logic                 csr_write;
   logic [REG_IDX_W-1:0] reg_idx;

   logic          accept;
   logic          out_free;
   logic          stage_advance;
   tick_info_type tick_info;
   logic          rom_rd_en;
   logic [ROM_AW-1:0]  rom_addr;
   logic [LEVEL_W-1:0] rom_data;

   logic               stage_valid_ff;
   tick_info_type      stage_info_ff;
   logic               rsp_valid_ff;
   logic [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;
   logic               rsp_strobe_ff;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[CSR_AW-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_mode_ff    <= RST_WAVE_MODE;
         sample_ticks_ff <= RST_SAMPLE_TICKS;
         high_ticks_ff   <= RST_HIGH_TICKS;
         low_ticks_ff    <= RST_LOW_TICKS;
      end else if (csr_write) begin
         case (reg_idx)
            REG_WAVE_MODE:    wave_mode_ff    <= csr_pwdata[MODE_W-1:0];
            REG_SAMPLE_TICKS: sample_ticks_ff <= csr_pwdata[SAMPLE_W-1:0];
            REG_HIGH_TICKS:   high_ticks_ff   <= csr_pwdata[WAIT_W-1:0];
            REG_LOW_TICKS:    low_ticks_ff    <= csr_pwdata[WAIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_WAVE_MODE:    csr_prdata = CSR_DW'(wave_mode_ff);
         REG_SAMPLE_TICKS: csr_prdata = CSR_DW'(sample_ticks_ff);
         REG_HIGH_TICKS:   csr_prdata = CSR_DW'(high_ticks_ff);
         REG_LOW_TICKS:    csr_prdata = CSR_DW'(low_ticks_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // flow control
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign stage_advance = stage_valid_ff && out_free;
   assign req_stall     = stage_valid_ff && !out_free;
   assign accept        = req_valid && !req_stall;

   dwg_tick_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_tick_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .run          (req_run),
      .wave_mode    (wave_mode_ff),
      .sample_ticks (sample_ticks_ff),
      .high_ticks   (high_ticks_ff),
      .low_ticks    (low_ticks_ff),
      .info         (tick_info),
      .rom_rd_en    (rom_rd_en),
      .rom_addr     (rom_addr)
   );

   dwg_sine_rom u_sine_rom (
      .clock   (clock),
      .rd_en   (rom_rd_en),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   // table read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (accept) begin
         stage_valid_ff <= 1'b1;
      end else if (stage_advance) begin
         stage_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_info_ff <= tick_info;
      end
   end

   // output register, also the held dac level
   always_comb begin
      rsp_level_in = rsp_level_ff;
      if (stage_info_ff.strobe) begin
         rsp_level_in = stage_info_ff.use_rom ? rom_data : stage_info_ff.level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         rsp_level_ff  <= LEVEL_LOW;
         rsp_strobe_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= stage_valid_ff;
         if (stage_valid_ff) begin
            rsp_level_ff  <= rsp_level_in;
            rsp_strobe_ff <= stage_info_ff.strobe;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dac_level    = rsp_level_ff;
   assign rsp_write_strobe = rsp_strobe_ff;

   assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !out_free |=> stage_valid_ff && $stable(stage_info_ff))
      else $error("blocked transaction lost from table read stage");

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> stage_valid_ff && rsp_valid_ff)
      else $error("input stalled with room in the pipeline");

   assert property (@(posedge clock) disable iff (reset)
      stage_advance && !stage_info_ff.strobe |=> $stable(rsp_level_ff))
      else $error("dac level changed without a write");

endmodule

/* tb/sv/dac_waveform_generator_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dac_waveform_generator_test
// Self-checking bench for the DAC waveform generator. Ticks with random run
// flags are sent in bursts while the output side stalls on its own pattern.
// A local generator model predicts each level and strobe. Registers are
// reprogrammed over APB between phases: square, triangle, sine and the spare
// mode, zero and large delays, then random settings.
// ----------------------------------------------------------------------------
module dac_waveform_generator_test;

   import dwg_pkg::*;

   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam int SAMPLE_MAX = 1000000;
   localparam int SQUARE_MAX = 2000000;
   localparam int RANDOM_TICKS = 500;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 6;
   localparam longint unsigned ANGLE_STEP = 64'd3373259426;
   localparam longint UNIT_FIXED = 64'sd1073741824;
   localparam longint ROUND_UP_BIAS = 64'sd2147483647 - 64'sd4096;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               strobe;
   } dac_sample_type;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_HEAVY} stall_kind_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_run = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [LEVEL_W-1:0]  rsp_dac_level;
   logic                rsp_write_strobe;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   // generator model: settings and state
   logic [MODE_W-1:0]   cfg_mode = RST_WAVE_MODE;
   logic [SAMPLE_W-1:0] cfg_sample_ticks = RST_SAMPLE_TICKS;
   logic [WAIT_W-1:0]   cfg_high_ticks = RST_HIGH_TICKS;
   logic [WAIT_W-1:0]   cfg_low_ticks = RST_LOW_TICKS;
   logic                gen_square_high = 1'b0;
   logic [WAIT_W-1:0]   gen_wait = '0;
   logic [ROM_AW-1:0]   gen_phase = '0;
   logic [LEVEL_W-1:0]  gen_held = '0;
   logic [LEVEL_W-1:0]  sine_levels [ROM_DEPTH];

   logic                pending_ticks [$];
   dac_sample_type      predicted_samples [$];
   logic                req_fired = 1'b0;
   int                  burst_left = 0;
   int                  gap_left = 0;
   int                  stall_left = 0;
   stall_kind_type      stall_kind = STALL_NONE;
   int                  quiet_cycles = 0;
   int                  error_count = 0;

   dac_waveform_generator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_run          (req_run),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_dac_level    (rsp_dac_level),
      .rsp_write_strobe (rsp_write_strobe),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin : clock_gen
      forever begin
         #5 clock = ~clock;
      end
   end

   // fixed-point sine: taylor terms up to x^15 in Q30, rounded up with a small margin
   function automatic logic [LEVEL_W-1:0] sine_point(int idx);
      longint unsigned angle;
      longint unsigned angle_sq;
      longint unsigned term;
      longint unsigned divisor;
      longint unsigned fold;
      longint          acc;
      longint          scaled;
      longint          lvl;
      int              h;
      h = idx % 256;
      fold = (h <= 128) ? h : 256 - h;
      angle = (fold * ANGLE_STEP + 64'd128) >> 8;
      angle_sq = (angle * angle) >> 30;
      term = angle;
      acc = longint'(angle);
      for (int k = 1; k <= 7; k++) begin
         divisor = (2 * k) * (2 * k + 1);
         term = ((term * angle_sq) >> 30) / divisor;
         if (k % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      scaled = (idx >= 256) ? 255 * (UNIT_FIXED - acc) : 255 * (UNIT_FIXED + acc);
      if (scaled < 0) begin
         scaled = 0;
      end
      lvl = (scaled + ROUND_UP_BIAS) / (64'sd1 <<< 31);
      if (lvl > 255) begin
         lvl = 255;
      end
      return lvl[LEVEL_W-1:0];
   endfunction

   function dac_sample_type advance_generator(logic run);
      logic [LEVEL_W-1:0] level;
      logic [WAIT_W-1:0]  delay;
      dac_sample_type     sample;
      sample.strobe = 1'b0;
      if (!run) begin
         gen_wait = '0;
      end else if (gen_wait != '0) begin
         gen_wait = gen_wait - 1'b1;
      end else begin
         if (cfg_mode == MODE_SQUARE) begin
            level = gen_square_high ? LEVEL_HIGH : LEVEL_LOW;
            delay = gen_square_high ? cfg_high_ticks : cfg_low_ticks;
            gen_square_high = ~gen_square_high;
         end else begin
            if (cfg_mode == MODE_TRIANGLE) begin
               level = gen_phase[8] ? ~gen_phase[7:0] : gen_phase[7:0];
            end else begin
               level = sine_levels[gen_phase];
            end
            delay = {1'b0, cfg_sample_ticks};
            gen_phase = gen_phase + 1'b1;
         end
         gen_held = level;
         gen_wait = (delay == '0) ? '0 : delay - 1'b1;
         sample.strobe = 1'b1;
      end
      sample.level = gen_held;
      return sample;
   endfunction

   function automatic int pick_ticks(int max_ticks);
      int choice;
      choice = $urandom_range(0, 15);
      if (choice == 0) begin
         return max_ticks;
      end else if (choice == 1) begin
         return $urandom_range(0, max_ticks);
      end
      return $urandom_range(0, 4);
   endfunction

   task automatic write_reg(logic [REG_IDX_W-1:0] idx, int unsigned value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      case (idx)
         REG_WAVE_MODE: begin
            cfg_mode = value[MODE_W-1:0];
         end
         REG_SAMPLE_TICKS: begin
            cfg_sample_ticks = value[SAMPLE_W-1:0];
         end
         REG_HIGH_TICKS: begin
            cfg_high_ticks = value[WAIT_W-1:0];
         end
         default: begin
            cfg_low_ticks = value[WAIT_W-1:0];
         end
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic program_generator(logic [MODE_W-1:0] mode, int sample_ticks,
                                    int high_ticks, int low_ticks);
      write_reg(REG_WAVE_MODE, 32'(mode));
      write_reg(REG_SAMPLE_TICKS, sample_ticks);
      write_reg(REG_HIGH_TICKS, high_ticks);
      write_reg(REG_LOW_TICKS, low_ticks);
   endtask

   task automatic add_ticks(int count, logic run);
      for (int i = 0; i < count; i++) begin
         pending_ticks.push_back(run);
      end
   endtask

   task automatic wait_idle();
      do begin
         @(posedge clock);
      end while (pending_ticks.size() != 0 || predicted_samples.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int random_count;
      int count;
      for (int i = 0; i < ROM_DEPTH; i++) begin
         sine_levels[i] = sine_point(i);
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: first running tick writes low, a stop restarts the count
      add_ticks(2, 1'b1);
      add_ticks(1, 1'b0);
      add_ticks(2, 1'b1);
      wait_idle();
      program_generator(MODE_TRIANGLE, 0, RST_HIGH_TICKS, RST_LOW_TICKS);
      add_ticks(4, 1'b1);
      wait_idle();
      program_generator(MODE_SINE, 2, RST_HIGH_TICKS, RST_LOW_TICKS);
      add_ticks(2, 1'b1);
      add_ticks(1, 1'b0);
      add_ticks(1, 1'b1);
      wait_idle();
      program_generator(MODE_SPARE, 0, RST_HIGH_TICKS, RST_LOW_TICKS);
      add_ticks(2, 1'b1);
      wait_idle();
      program_generator(MODE_SQUARE, 0, 0, 0);
      add_ticks(4, 1'b1);
      wait_idle();
      program_generator(MODE_TRIANGLE, SAMPLE_MAX, SQUARE_MAX, SQUARE_MAX);
      add_ticks(3, 1'b1);
      wait_idle();
      program_generator(MODE_SQUARE, SAMPLE_MAX, SQUARE_MAX, SQUARE_MAX);
      add_ticks(3, 1'b1);

      random_count = 0;
      while (random_count < RANDOM_TICKS) begin
         wait_idle();
         program_generator(MODE_W'($urandom_range(0, 3)), pick_ticks(SAMPLE_MAX),
                           pick_ticks(SQUARE_MAX), pick_ticks(SQUARE_MAX));
         count = $urandom_range(20, 60);
         for (int i = 0; i < count; i++) begin
            pending_ticks.push_back($urandom_range(0, 9) != 0);
         end
         random_count += count;
      end
      wait_idle();

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   always @(negedge clock) begin : tick_driver
      if (req_fired) begin
         void'(pending_ticks.pop_front());
      end
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fired) begin
         // stalled transaction stays put
      end else if (gap_left != 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (pending_ticks.size() != 0) begin
         req_valid <= 1'b1;
         req_run <= pending_ticks[0];
         if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         end else begin
            burst_left--;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin : rsp_pacer
      if (stall_left == 0) begin
         stall_left = $urandom_range(1, 40);
         stall_kind = stall_kind_type'($urandom_range(0, 2));
      end
      stall_left--;
      case (stall_kind)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_RANDOM: begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
         end
         default: begin
            rsp_stall <= (stall_left % 4 != 0);
         end
      endcase
   end

   always @(posedge clock) begin : req_observe
      if (!reset && req_valid && !req_stall) begin
         predicted_samples.push_back(advance_generator(req_run));
         req_fired <= 1'b1;
      end else begin
         req_fired <= 1'b0;
      end
   end

   always @(posedge clock) begin : rsp_check
      dac_sample_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_samples.size() == 0) begin
            $error("unexpected transaction: dac_level %0d write_strobe %0d",
                   rsp_dac_level, rsp_write_strobe);
            error_count++;
         end else begin
            want = predicted_samples.pop_front();
            if (rsp_dac_level !== want.level) begin
               $error("dac_level mismatch: expected %0d, got %0d", want.level, rsp_dac_level);
               error_count++;
            end
            if (rsp_write_strobe !== want.strobe) begin
               $error("write_strobe mismatch: expected %0d, got %0d",
                      want.strobe, rsp_write_strobe);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || csr_psel || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
